// File: rtl/pidc_pkg.sv
`default_nettype none

package pidc_pkg;

   localparam int VW = 32;            // value width
   localparam int FB = 16;            // fraction bits
   localparam int QW = VW + FB;       // wide quotient / shifted product width
   localparam int CW = 3;             // csr index width

   localparam logic [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
   localparam logic [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};
   localparam logic [VW-1:0] HALF = VW'(180) << FB;
   localparam logic [VW-1:0] FULL = VW'(360) << FB;

   localparam logic OP_STEP  = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   localparam logic [CW-1:0] REG_GAIN_P    = 3'd0;
   localparam logic [CW-1:0] REG_GAIN_I    = 3'd1;
   localparam logic [CW-1:0] REG_GAIN_D    = 3'd2;
   localparam logic [CW-1:0] REG_SCALE     = 3'd3;
   localparam logic [CW-1:0] REG_LIMIT     = 3'd4;
   localparam logic [CW-1:0] REG_WRAP      = 3'd5;
   localparam logic [CW-1:0] REG_EXT_RATE  = 3'd6;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ERR,
      ST_WRAP,
      ST_MUL_I,
      ST_DIV_D,
      ST_MUL_P,
      ST_MUL_I2,
      ST_MUL_D,
      ST_MUL_S,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

   // sign and magnitude to saturated signed value
   function automatic logic [VW-1:0] sat_mag(input logic neg, input logic [QW-1:0] m);
      logic [VW-1:0] r;
      if (neg) begin
         if (m >= QW'(VMIN)) r = VMIN;
         else r = ~m[VW-1:0] + VW'(1);
      end else begin
         if (m > QW'(VMAX)) r = VMAX;
         else r = m[VW-1:0];
      end
      return r;
   endfunction

   function automatic logic [VW-1:0] sat_add(input logic [VW-1:0] a, input logic [VW-1:0] b);
      logic [VW:0] s;
      logic [VW-1:0] r;
      s = {a[VW-1], a} + {b[VW-1], b};
      if (s[VW] != s[VW-1]) r = s[VW] ? VMIN : VMAX;
      else r = s[VW-1:0];
      return r;
   endfunction

endpackage

`default_nettype wire

// File: rtl/pidc_mul.sv
`default_nettype none

// Radix-2 shift-add multiplier on magnitudes; result is the product
// shifted right by the fraction bits, truncated toward zero and saturated.
module pidc_mul (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [pidc_pkg::VW-1:0]    a,
   input  wire logic [pidc_pkg::VW-1:0]    b,
   output pidc_pkg::unit_stat_type         stat,
   output logic      [pidc_pkg::VW-1:0]    result
);

   localparam int W = pidc_pkg::VW;

   logic [W-1:0]          mcand_ff, mcand_in;
   logic [W-1:0]          mplier_ff, mplier_in;
   logic [W:0]            acc_ff, acc_in;
   logic [W-1:0]          lo_ff, lo_in;
   logic                  neg_ff, neg_in;
   logic [$clog2(W)-1:0]  cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [W:0]            sum;
   logic [2*W-1:0]        prod;

   always_comb begin
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      lo_in     = lo_ff;
      neg_in    = neg_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      sum       = acc_ff + (mplier_ff[0] ? {1'b0, mcand_ff} : '0);
      if (start && !busy_ff) begin
         mcand_in  = a[W-1] ? (~a + W'(1)) : a;
         mplier_in = b[W-1] ? (~b + W'(1)) : b;
         neg_in    = a[W-1] ^ b[W-1];
         acc_in    = '0;
         lo_in     = '0;
         cnt_in    = '0;
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         acc_in    = {1'b0, sum[W:1]};
         lo_in     = {sum[0], lo_ff[W-1:1]};
         mplier_in = {1'b0, mplier_ff[W-1:1]};
         cnt_in    = cnt_ff + 1'b1;
         if (cnt_ff == ($clog2(W))'(W-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
      lo_ff     <= lo_in;
      neg_ff    <= neg_in;
      cnt_ff    <= cnt_in;
   end

   assign prod        = {acc_ff[W-1:0], lo_ff};
   assign result      = pidc_pkg::sat_mag(neg_ff, prod[2*W-1:pidc_pkg::FB]);
   assign stat.busy   = busy_ff;
   assign stat.done   = done_ff;

endmodule

`default_nettype wire

// File: rtl/pidc_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle. The numerator register
// turns into the quotient as it shifts.
module pidc_div (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [pidc_pkg::QW-1:0]    num,
   input  wire logic [pidc_pkg::VW-2:0]    den,
   output pidc_pkg::unit_stat_type         stat,
   output logic      [pidc_pkg::QW-1:0]    quot,
   output logic      [pidc_pkg::VW-1:0]    rem
);

   localparam int W = pidc_pkg::VW;
   localparam int Q = pidc_pkg::QW;

   logic [Q-1:0]          num_ff, num_in;
   logic [W-2:0]          den_ff, den_in;
   logic [W-1:0]          rem_ff, rem_in;
   logic [$clog2(Q)-1:0]  cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [W:0]            trial;
   logic [W:0]            diff;

   always_comb begin
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, num_ff[Q-1]};
      diff    = trial - {2'b00, den_ff};
      if (start && !busy_ff) begin
         num_in  = num;
         den_in  = den;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {2'b00, den_ff}) begin
            rem_in = diff[W-1:0];
            num_in = {num_ff[Q-2:0], 1'b1};
         end else begin
            rem_in = trial[W-1:0];
            num_in = {num_ff[Q-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == ($clog2(Q))'(Q-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   assign quot      = num_ff;
   assign rem       = rem_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

`default_nettype wire

// File: rtl/pid_step_with_integrator_clamp.sv
`default_nettype none
// One item at a time, using the shared bit-serial multiplier
// (five products) and the restoring divider (used for the angle wrap and for
// the error-change derivative).
// Reset (synchronous, active high) zeroes gains, limit, mode bits, integrator and
// previous error, and sets the output scale to 1.0.
module pid_step_with_integrator_clamp (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_op,
   input  wire logic [31:0] req_target,
   input  wire logic [31:0] req_measured,
   input  wire logic [30:0] req_time_step,
   input  wire logic [31:0] req_measured_rate,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_drive,
   output logic             rsp_integral_clamped,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_data
);

   localparam int W = pidc_pkg::VW;

   pidc_pkg::state_type state_ff, state_in;

   logic [W-1:0] gain_p_ff, gain_i_ff, gain_d_ff, scale_ff;
   logic [W-2:0] limit_ff;
   logic         wrap_ff, ext_ff;

   logic [W-1:0] tgt_ff, meas_ff, rate_ff;
   logic [W-2:0] dt_ff;
   logic [W-1:0] integ_ff, prev_ff, err_ff, deriv_ff, sum_ff;
   logic         clamped_ff;
   logic         launched_ff;
   logic         rsp_valid_ff;
   logic [W-1:0] rsp_drive_ff;
   logic         rsp_clamped_ff;

   pidc_pkg::unit_stat_type mul_stat, div_stat;
   logic [W-1:0]            mul_a, mul_b, mul_res;
   logic                    mul_start, div_start;
   logic [pidc_pkg::QW-1:0] div_num, div_quot;
   logic [W-2:0]            div_den;
   logic [W-1:0]            div_rem;

   logic [W:0]   d, dmag;
   logic         dneg;
   logic         wrap_case;
   logic [W-1:0] err_sat;
   logic [W:0]   e, emag;
   logic         eneg;
   logic [W-1:0] wrap_s, wrap_err;
   logic [W-1:0] integ_sum;
   logic [W:0]   lim33;
   logic         out_free;
   logic         in_mul, in_div;

   // error difference and angle wrap decision
   always_comb begin
      d         = {tgt_ff[W-1], tgt_ff} - {meas_ff[W-1], meas_ff};
      dneg      = d[W];
      dmag      = dneg ? (~d + (W+1)'(1)) : d;
      wrap_case = wrap_ff && ((!dneg && dmag >= {1'b0, pidc_pkg::HALF}) ||
                              (dneg && dmag > {1'b0, pidc_pkg::HALF}));
      if (d[W] != d[W-1]) err_sat = d[W] ? pidc_pkg::VMIN : pidc_pkg::VMAX;
      else err_sat = d[W-1:0];
      wrap_s = {7'd0, div_rem[24:0]} + pidc_pkg::HALF;
      if (wrap_s >= pidc_pkg::FULL) wrap_s = wrap_s - pidc_pkg::FULL;
      wrap_err = dneg ? (pidc_pkg::HALF - wrap_s) : (wrap_s - pidc_pkg::HALF);
      e    = {err_ff[W-1], err_ff} - {prev_ff[W-1], prev_ff};
      eneg = e[W];
      emag = eneg ? (~e + (W+1)'(1)) : e;
      integ_sum = pidc_pkg::sat_add(integ_ff, mul_res);
      lim33     = {2'b00, limit_ff};
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pidc_pkg::ST_IDLE:
            if (req_valid && req_op == pidc_pkg::OP_STEP) state_in = pidc_pkg::ST_ERR;
         pidc_pkg::ST_ERR:
            state_in = wrap_case ? pidc_pkg::ST_WRAP : pidc_pkg::ST_MUL_I;
         pidc_pkg::ST_WRAP:
            if (div_stat.done) state_in = pidc_pkg::ST_MUL_I;
         pidc_pkg::ST_MUL_I:
            if (mul_stat.done) begin
               if (ext_ff || emag == '0) state_in = pidc_pkg::ST_MUL_P;
               else state_in = pidc_pkg::ST_DIV_D;
            end
         pidc_pkg::ST_DIV_D:
            if (div_stat.done) state_in = pidc_pkg::ST_MUL_P;
         pidc_pkg::ST_MUL_P:
            if (mul_stat.done) state_in = pidc_pkg::ST_MUL_I2;
         pidc_pkg::ST_MUL_I2:
            if (mul_stat.done) state_in = pidc_pkg::ST_MUL_D;
         pidc_pkg::ST_MUL_D:
            if (mul_stat.done) state_in = pidc_pkg::ST_MUL_S;
         pidc_pkg::ST_MUL_S:
            if (mul_stat.done) state_in = pidc_pkg::ST_DONE;
         pidc_pkg::ST_DONE:
            if (out_free) state_in = pidc_pkg::ST_IDLE;
         default:
            state_in = pidc_pkg::ST_IDLE;
      endcase
   end

   // unit control and operand selection
   always_comb begin
      in_mul = 1'b0;
      in_div = 1'b0;
      mul_a  = err_ff;
      mul_b  = {1'b0, dt_ff};
      div_num = {emag[W-1:0], {pidc_pkg::FB{1'b0}}};
      div_den = dt_ff;
      case (state_ff)
         pidc_pkg::ST_WRAP: begin
            in_div  = 1'b1;
            div_num = {{(pidc_pkg::QW-W-1){1'b0}}, dmag};
            div_den = pidc_pkg::FULL[W-2:0];
         end
         pidc_pkg::ST_MUL_I:  in_mul = 1'b1;
         pidc_pkg::ST_DIV_D:  in_div = 1'b1;
         pidc_pkg::ST_MUL_P: begin
            in_mul = 1'b1;
            mul_a  = gain_p_ff;
            mul_b  = err_ff;
         end
         pidc_pkg::ST_MUL_I2: begin
            in_mul = 1'b1;
            mul_a  = gain_i_ff;
            mul_b  = integ_ff;
         end
         pidc_pkg::ST_MUL_D: begin
            in_mul = 1'b1;
            mul_a  = gain_d_ff;
            mul_b  = deriv_ff;
         end
         pidc_pkg::ST_MUL_S: begin
            in_mul = 1'b1;
            mul_a  = scale_ff;
            mul_b  = sum_ff;
         end
         default: begin
            in_mul = 1'b0;
            in_div = 1'b0;
         end
      endcase
      mul_start = in_mul && !launched_ff;
      div_start = in_div && !launched_ff;
   end

   pidc_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .a      (mul_a),
      .b      (mul_b),
      .stat   (mul_stat),
      .result (mul_res)
   );

   pidc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .stat  (div_stat),
      .quot  (div_quot),
      .rem   (div_rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= pidc_pkg::ST_IDLE;
         launched_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         gain_p_ff      <= '0;
         gain_i_ff      <= '0;
         gain_d_ff      <= '0;
         scale_ff       <= W'(1) << pidc_pkg::FB;
         limit_ff       <= '0;
         wrap_ff        <= 1'b0;
         ext_ff         <= 1'b0;
         integ_ff       <= '0;
         prev_ff        <= '0;
      end else begin
         state_ff <= state_in;
         if (mul_start || div_start) launched_ff <= 1'b1;
         else if (mul_stat.done || div_stat.done) launched_ff <= 1'b0;

         if (csr_valid) begin
            case (csr_index)
               pidc_pkg::REG_GAIN_P:   gain_p_ff <= csr_data;
               pidc_pkg::REG_GAIN_I:   gain_i_ff <= csr_data;
               pidc_pkg::REG_GAIN_D:   gain_d_ff <= csr_data;
               pidc_pkg::REG_SCALE:    scale_ff  <= csr_data;
               pidc_pkg::REG_LIMIT:    limit_ff  <= csr_data[W-2:0];
               pidc_pkg::REG_WRAP:     wrap_ff   <= csr_data[0];
               pidc_pkg::REG_EXT_RATE: ext_ff    <= csr_data[0];
               default: ;
            endcase
         end

         if (state_ff == pidc_pkg::ST_IDLE && req_valid && req_op == pidc_pkg::OP_CLEAR) begin
            integ_ff <= '0;
            prev_ff  <= '0;
         end
         if (state_ff == pidc_pkg::ST_MUL_I && mul_stat.done) begin
            if ($signed({integ_sum[W-1], integ_sum}) > $signed(lim33)) begin
               integ_ff   <= {1'b0, limit_ff};
               clamped_ff <= 1'b1;
            end else if ($signed({integ_sum[W-1], integ_sum}) < -$signed(lim33)) begin
               integ_ff   <= ~{1'b0, limit_ff} + W'(1);
               clamped_ff <= 1'b1;
            end else begin
               integ_ff   <= integ_sum;
               clamped_ff <= 1'b0;
            end
         end
         if (state_ff == pidc_pkg::ST_MUL_P && mul_stat.done) prev_ff <= err_ff;

         if (state_ff == pidc_pkg::ST_DONE && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end

      if (state_ff == pidc_pkg::ST_IDLE && req_valid) begin
         tgt_ff  <= req_target;
         meas_ff <= req_measured;
         dt_ff   <= req_time_step;
         rate_ff <= req_measured_rate;
      end
      if (state_ff == pidc_pkg::ST_ERR) err_ff <= err_sat;
      if (state_ff == pidc_pkg::ST_WRAP && div_stat.done) err_ff <= wrap_err;

      if (state_ff == pidc_pkg::ST_MUL_I && mul_stat.done) begin
         if (ext_ff) deriv_ff <= (rate_ff == pidc_pkg::VMIN) ? pidc_pkg::VMAX
                                                             : (~rate_ff + W'(1));
         else deriv_ff <= '0;   // zero error change
      end
      if (state_ff == pidc_pkg::ST_DIV_D && div_stat.done)
         deriv_ff <= pidc_pkg::sat_mag(eneg, div_quot);

      if (mul_stat.done) begin
         case (state_ff)
            pidc_pkg::ST_MUL_P:  sum_ff <= mul_res;
            pidc_pkg::ST_MUL_I2: sum_ff <= pidc_pkg::sat_add(sum_ff, mul_res);
            pidc_pkg::ST_MUL_D:  sum_ff <= pidc_pkg::sat_add(sum_ff, mul_res);
            pidc_pkg::ST_MUL_S:  sum_ff <= mul_res;
            default: ;
         endcase
      end

      if (state_ff == pidc_pkg::ST_DONE && out_free) begin
         rsp_drive_ff   <= sum_ff;
         rsp_clamped_ff <= clamped_ff;
      end
   end

   assign req_ready            = (state_ff == pidc_pkg::ST_IDLE);
   assign csr_ready            = 1'b1;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_drive            = rsp_drive_ff;
   assign rsp_integral_clamped = rsp_clamped_ff;

   a_one_unit: assert property (@(posedge clock) disable iff (reset)
      !(mul_stat.busy && div_stat.busy))
      else $error("multiplier and divider busy together");

   a_step_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_op == pidc_pkg::OP_STEP) |=> state_ff == pidc_pkg::ST_ERR)
      else $error("accepted step item did not start");

   a_mul_done_owned: assert property (@(posedge clock) disable iff (reset)
      mul_stat.done |-> (state_ff == pidc_pkg::ST_MUL_I || state_ff == pidc_pkg::ST_MUL_P ||
                         state_ff == pidc_pkg::ST_MUL_I2 || state_ff == pidc_pkg::ST_MUL_D ||
                         state_ff == pidc_pkg::ST_MUL_S))
      else $error("multiplier finished outside a product state");

   a_done_gives_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pidc_pkg::ST_DONE && out_free) |=> rsp_valid)
      else $error("finished item not presented");

endmodule

`default_nettype wire
